/* rtl/core/planar_subtile_fetch_decoder_core_defines.svh */
// Assertion macros for the decoder RTL.
`ifndef PLANAR_SUBTILE_FETCH_DECODER_CORE_DEFINES_SVH
`define PLANAR_SUBTILE_FETCH_DECODER_CORE_DEFINES_SVH
`ifndef SYNTH
// Check a property on every rising edge, suspended while reset is active.
`define PSFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define PSFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PSFD_ASSERT(name, prop, msg)
`define PSFD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* rtl/core/psfd_pkg.sv */
package psfd_pkg;

  localparam int CHIP_DEPTH  = 16384;
  localparam int MAX_CHIPS   = 8;
  localparam int STORE_DEPTH = CHIP_DEPTH * MAX_CHIPS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int OFF_W       = 18;
  localparam int BASE_W      = 27;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_QUAD = 2'd1,
    STAT_OVERRUN  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_CHIP_MODE   = 3'd0,
    REG_BLOCK_SIZE  = 3'd1,
    REG_LINEAR_SIZE = 3'd2,
    REG_CHIP_BYTES  = 3'd3,
    REG_CHIP_TOTAL  = 3'd4
  } reg_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    logic        chip_mode;
    logic [2:0]  block_size;
    logic [17:0] linear_size;
    logic [14:0] eff_bytes;
    logic [3:0]  eff_chips;
  } cfg_t;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    status_e           status;
    logic [OFF_W-1:0]  base;
    logic              stride16;
  } cmd_t;

  // Interleave four plane bytes into eight nibbles, leftmost pixel on top.
  function automatic logic [31:0] pack_row(input logic [7:0] p0, input logic [7:0] p1,
                                           input logic [7:0] p2, input logic [7:0] p3);
    logic [31:0] word;
    word = '0;
    for (int x = 0; x < 8; x++) begin
      word[28-4*x +: 4] = {p3[7-x], p2[7-x], p1[7-x], p0[7-x]};
    end
    return word;
  endfunction

endpackage

/* rtl/core/planar_subtile_fetch_decoder_core.sv */
// Throughput: a decode reads one store byte a cycle through the store's single read port
// (eight rows of four plane bytes) while the output is not stalled; loads write the store
// directly and error results skip the read.
// A two-entry queue lets the front accept while the back is busy.
// Reset: clears control state and the config registers to their defaults; the store is not cleared.
module planar_subtile_fetch_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [16:0] load_address_i,
  input  logic [7:0]  load_data_i,
  input  logic [15:0] tile_code_i,
  input  logic [1:0]  quad_x_i,
  input  logic [1:0]  quad_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] row_pixels_o,
  output logic [2:0]  row_number_o,
  output logic        last_row_o,
  output logic [1:0]  status_o
);

  logic           chip_mode_q;
  logic [2:0]     block_size_q;
  logic [17:0]    linear_size_q;
  logic [14:0]    chip_bytes_q;
  logic [3:0]     chip_total_q;
  logic           wr_en;
  psfd_pkg::cfg_t cfg;
  psfd_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, full, empty;

  // Register write on the access phase; pready is tied high.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_mode_q   <= 1'b0;
      block_size_q  <= 3'd1;
      linear_size_q <= '0;
      chip_bytes_q  <= 15'(psfd_pkg::CHIP_DEPTH);
      chip_total_q  <= 4'(psfd_pkg::MAX_CHIPS);
    end else if (wr_en) begin
      case (psfd_pkg::reg_e'(paddr[4:2]))
        psfd_pkg::REG_CHIP_MODE:   chip_mode_q   <= pwdata[0];
        psfd_pkg::REG_BLOCK_SIZE:  block_size_q  <= pwdata[2:0];
        psfd_pkg::REG_LINEAR_SIZE: linear_size_q <= pwdata[17:0];
        psfd_pkg::REG_CHIP_BYTES:  chip_bytes_q  <= pwdata[14:0];
        psfd_pkg::REG_CHIP_TOTAL:  chip_total_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (psfd_pkg::reg_e'(paddr[4:2]))
      psfd_pkg::REG_CHIP_MODE:   prdata = 32'(chip_mode_q);
      psfd_pkg::REG_BLOCK_SIZE:  prdata = 32'(block_size_q);
      psfd_pkg::REG_LINEAR_SIZE: prdata = 32'(linear_size_q);
      psfd_pkg::REG_CHIP_BYTES:  prdata = 32'(chip_bytes_q);
      psfd_pkg::REG_CHIP_TOTAL:  prdata = 32'(chip_total_q);
      default:                   prdata = '0;
    endcase
  end

  // Saturate the chip geometry once, shared by front and back.
  always_comb begin
    cfg.chip_mode   = chip_mode_q;
    cfg.block_size  = block_size_q;
    cfg.linear_size = linear_size_q;
    cfg.eff_bytes   = (32'(chip_bytes_q) > psfd_pkg::CHIP_DEPTH) ?
                      15'(psfd_pkg::CHIP_DEPTH) : chip_bytes_q;
    cfg.eff_chips   = (32'(chip_total_q) > psfd_pkg::MAX_CHIPS) ?
                      4'(psfd_pkg::MAX_CHIPS) : chip_total_q;
  end

  // Front: accept and classify each transaction (load, decode, or error).
  psfd_front u_front (
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .load_address_i (load_address_i),
    .load_data_i    (load_data_i),
    .tile_code_i    (tile_code_i),
    .quad_x_i       (quad_x_i),
    .quad_y_i       (quad_y_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // Queue: hold classified commands in order, loads and decodes alike.
  psfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .full_o     (full),
    .empty_o    (empty)
  );

  // Back: own the store, fetch plane bytes and emit rows through an output register.
  psfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_pixels_o (row_pixels_o),
    .row_number_o (row_number_o),
    .last_row_o   (last_row_o),
    .status_o     (status_o)
  );

endmodule

/* rtl/core/psfd_front.sv */
module psfd_front (
  input  psfd_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [16:0]         load_address_i,
  input  logic [7:0]          load_data_i,
  input  logic [15:0]         tile_code_i,
  input  logic [1:0]          quad_x_i,
  input  logic [1:0]          quad_y_i,
  input  logic                full_i,
  output logic                push_o,
  output psfd_pkg::cmd_t      cmd_o
);

  logic [17:0]                 gfx;
  logic [2:0]                  bs;
  logic                        bad;
  logic                        s16;
  logic [5:0]                  bs2;
  logic [10:0]                 tile_span;
  logic [psfd_pkg::BASE_W-1:0] row_off, col_off, base_full, end_full;
  logic                        overrun;

  // Graphics size follows the registers directly, so a write takes effect at once.
  assign gfx = cfg_i.chip_mode ? 18'({3'b0, cfg_i.eff_bytes} * {14'b0, cfg_i.eff_chips})
                               : cfg_i.linear_size;

  always_comb begin
    bs         = cfg_i.block_size;
    bad        = (bs == 3'd0) || (bs > 3'd4) || ({1'b0, quad_x_i} >= bs) ||
                 ({1'b0, quad_y_i} >= bs);
    s16        = (bs == 3'd4);
    bs2        = {3'b0, bs} * {3'b0, bs};
    tile_span  = {bs2, 5'b0};
    row_off    = s16 ? psfd_pkg::BASE_W'({quad_y_i, 7'b0})
                     : psfd_pkg::BASE_W'({quad_y_i, 6'b0});
    col_off    = psfd_pkg::BASE_W'({quad_x_i, 2'b0});
    base_full  = psfd_pkg::BASE_W'({11'b0, tile_code_i} * {16'b0, tile_span}) +
                 row_off + col_off;
    end_full   = base_full + (s16 ? psfd_pkg::BASE_W'(7 * 16 + 4)
                                  : psfd_pkg::BASE_W'(7 * 8 + 4));
    overrun    = end_full > psfd_pkg::BASE_W'(gfx);

    cmd_o.func     = psfd_pkg::func_e'(func_i);
    cmd_o.addr     = load_address_i;
    cmd_o.data     = load_data_i;
    cmd_o.status   = bad ? psfd_pkg::STAT_BAD_QUAD :
                     overrun ? psfd_pkg::STAT_OVERRUN : psfd_pkg::STAT_OK;
    cmd_o.base     = base_full[psfd_pkg::OFF_W-1:0];
    cmd_o.stride16 = s16;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

/* rtl/core/psfd_queue.sv */
module psfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  psfd_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output psfd_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  psfd_pkg::cmd_t                entry_q [psfd_pkg::QUEUE_DEPTH];
  logic [psfd_pkg::PTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [psfd_pkg::PTR_W:0]      cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (psfd_pkg::PTR_W + 1)'(push_i) - (psfd_pkg::PTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  assign head_o  = entry_q[rd_q];
  assign full_o  = (cnt_q == (psfd_pkg::PTR_W + 1)'(psfd_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

/* rtl/core/psfd_back.sv */
`include "planar_subtile_fetch_decoder_core_defines.svh"

module psfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psfd_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  psfd_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    row_pixels_o,
  output logic [2:0]     row_number_o,
  output logic           last_row_o,
  output logic [1:0]     status_o
);

  logic [7:0]                  mem [psfd_pkg::STORE_DEPTH];

  psfd_pkg::back_state_e       state_q, state_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic [psfd_pkg::OFF_W-1:0]  base_q, base_d;
  logic                        s16_q, s16_d;

  logic                        cap_v_q, cap_v_d;
  logic [2:0]                  cap_y_q;
  logic [1:0]                  cap_pl_q;
  logic                        cap_zero_q;
  logic [7:0]                  rd_q;
  logic [7:0]                  p0_q, p1_q, p2_q;

  logic                        out_v_q, out_v_d;
  logic [31:0]                 pix_q;
  logic [2:0]                  rnum_q;
  logic                        last_q;
  psfd_pkg::status_e           stat_q;

  logic                        out_free, cap_hold, cap_take, issue, we, err_load;
  logic [psfd_pkg::OFF_W-1:0]  off, o;
  logic [16:0]                 hb;
  logic                        half;
  logic [2:0]                  chip;
  logic [15:0]                 idx;
  logic                        rd_zero;
  logic [psfd_pkg::ADDR_W-1:0] raddr;
  logic [7:0]                  cap_byte;

  // Map the current byte offset to a store address.
  always_comb begin
    off  = base_q + (s16_q ? psfd_pkg::OFF_W'({cnt_q[4:2], 4'b0})
                           : psfd_pkg::OFF_W'({cnt_q[4:2], 3'b0})) +
           psfd_pkg::OFF_W'(cnt_q[1:0]);
    hb   = {cfg_i.eff_bytes, 2'b0};
    half = off >= {1'b0, hb};
    o    = half ? off - {1'b0, hb} : off;
    chip = {half, o[2:1]};
    idx  = {o[17:3], o[0]};
    if (cfg_i.chip_mode) begin
      rd_zero = ({1'b0, chip} >= cfg_i.eff_chips) || (idx >= {1'b0, cfg_i.eff_bytes});
      raddr   = psfd_pkg::ADDR_W'(chip) * psfd_pkg::ADDR_W'(psfd_pkg::CHIP_DEPTH) +
                psfd_pkg::ADDR_W'(idx);
    end else begin
      rd_zero = off >= psfd_pkg::OFF_W'(psfd_pkg::STORE_DEPTH);
      raddr   = off[psfd_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    out_free = !out_v_q || !out_stall_i;
    cap_hold = cap_v_q && (cap_pl_q == 2'd3) && !out_free;
    cap_take = cap_v_q && !cap_hold;
    cap_byte = cap_zero_q ? 8'd0 : rd_q;

    state_d  = state_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    s16_d    = s16_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    err_load = 1'b0;
    issue    = 1'b0;

    case (state_q)
      psfd_pkg::BK_IDLE: begin
        if (!empty_i && !cap_v_q) begin
          case (head_i.func)
            psfd_pkg::FUNC_LOAD: begin
              pop_o = 1'b1;
              we    = 1'b1;
            end
            psfd_pkg::FUNC_DECODE: begin
              if (head_i.status != psfd_pkg::STAT_OK) begin
                if (out_free) begin
                  pop_o    = 1'b1;
                  err_load = 1'b1;
                end
              end else begin
                pop_o   = 1'b1;
                base_d  = head_i.base;
                s16_d   = head_i.stride16;
                cnt_d   = '0;
                state_d = psfd_pkg::BK_READ;
              end
            end
            default: ;
          endcase
        end
      end
      psfd_pkg::BK_READ: begin
        issue = !cap_hold;
        if (issue) begin
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_d = psfd_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = psfd_pkg::BK_IDLE;
    endcase

    cap_v_d = issue || cap_hold;

    out_v_d = out_v_q && out_stall_i;
    if (err_load || (cap_take && cap_pl_q == 2'd3)) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psfd_pkg::BK_IDLE;
      cnt_q   <= '0;
      cap_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cap_v_q <= cap_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Store and read port: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[head_i.addr] <= head_i.data;
    end
    if (issue) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    s16_q  <= s16_d;
    if (issue) begin
      cap_y_q    <= cnt_q[4:2];
      cap_pl_q   <= cnt_q[1:0];
      cap_zero_q <= rd_zero;
    end
    if (cap_take) begin
      case (cap_pl_q)
        2'd0:    p0_q <= cap_byte;
        2'd1:    p1_q <= cap_byte;
        2'd2:    p2_q <= cap_byte;
        default: ;
      endcase
    end
    if (err_load) begin
      pix_q  <= '0;
      rnum_q <= '0;
      last_q <= 1'b1;
      stat_q <= head_i.status;
    end else if (cap_take && cap_pl_q == 2'd3) begin
      pix_q  <= psfd_pkg::pack_row(p0_q, p1_q, p2_q, cap_byte);
      rnum_q <= cap_y_q;
      last_q <= (cap_y_q == 3'd7);
      stat_q <= psfd_pkg::STAT_OK;
    end
  end

  assign out_valid_o  = out_v_q;
  assign row_pixels_o = pix_q;
  assign row_number_o = rnum_q;
  assign last_row_o   = last_q;
  assign status_o     = stat_q;

  `PSFD_ASSERT(a_row_lands, (cap_take && cap_pl_q == 2'd3) |=> out_v_q, "row lost on capture")
  `PSFD_ASSERT(a_idle_pop_clear, (state_q == psfd_pkg::BK_IDLE && pop_o) |-> !cap_v_q, "pop while capture busy")
  `PSFD_ASSERT_ALWAYS(a_last_row_seven, (out_v_q && last_q && stat_q == psfd_pkg::STAT_OK) |-> rnum_q == 3'd7, "last row not seven")

endmodule
